// ===== rtl/core/tes_pkg.sv =====
// Package for the timestamp elapsed-seconds block.
// Holds field widths, the captured-word struct and the calendar helpers.
// Used by tes_in_stage, tes_calc and timestamp_elapsed_seconds.
package tes_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int IN_DATA_W  = 40;
  localparam int ELAPSED_W  = 26;
  localparam int OUT_DATA_W = 32;
  localparam int HRS_W    = 15;
  localparam int SOH_W    = 12;

  localparam logic [13:0] HOURS_YEAR      = 14'd8760;
  localparam logic [13:0] HOURS_LEAP_YEAR = 14'd8784;
  localparam logic [3:0]  MONTH_UNSET     = 4'd0;
  localparam logic [3:0]  MONTH_FEB       = 4'd2;
  localparam logic [3:0]  FULL_YEAR_IDX   = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic                leap;
  } tes_item_t;

  function automatic logic [8:0] days_before(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

  function automatic logic signed [HRS_W-1:0] hours_into_year(
    input logic               leap,
    input logic [MONTH_W-1:0] m,
    input logic [DAY_W-1:0]   d,
    input logic [HOUR_W-1:0]  h
  );
    logic [3:0]               full;
    logic [13:0]              base;
    logic signed [5:0]        d_m1;
    logic signed [HRS_W-1:0]  dterm;
    logic signed [HRS_W-1:0]  acc;
    full = (m == MONTH_UNSET) ? 4'd0 : m - 4'd1;
    if (full > FULL_YEAR_IDX) begin
      full = FULL_YEAR_IDX;
    end
    base  = 14'(days_before(full)) * 14'd24;
    d_m1  = $signed({1'b0, d}) - 6'sd1;
    dterm = $signed({{(HRS_W-6){d_m1[5]}}, d_m1}) * 15'sd24;
    acc   = $signed({1'b0, base}) + dterm + $signed({{(HRS_W-HOUR_W){1'b0}}, h});
    if (leap && (m > MONTH_FEB)) begin
      acc = acc + 15'sd24;
    end
    return acc;
  endfunction

endpackage

// ===== rtl/core/tes_in_stage.sv =====
// Input register stage: captures one timestamp word and its leap-year flag.
// Depends on tes_pkg.
module tes_in_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tes_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           s1_valid,
  input  logic                           s1_ready,
  output tes_pkg::tes_item_t             s1_item
);
  import tes_pkg::*;

  logic                s1_valid_r;
  tes_item_t           s1_item_r;
  tes_item_t           item_nxt;
  logic [26:0]         quot_prod;
  logic [9:0]          quot;
  logic [YEAR_W-1:0]   quot_x25;
  logic                div25;

  // year / 25 by reciprocal, exact over 14 bits
  always_comb begin
    item_nxt.year   = in_tdata[13:0];
    item_nxt.month  = in_tdata[17:14];
    item_nxt.day    = in_tdata[22:18];
    item_nxt.hour   = in_tdata[27:23];
    item_nxt.minute = in_tdata[33:28];
    item_nxt.second = in_tdata[39:34];
    quot_prod = 27'(item_nxt.year) * 27'd5243;
    quot      = quot_prod[26:17];
    quot_x25  = 14'(quot) * 14'd25;
    div25     = (item_nxt.year == quot_x25);
    item_nxt.leap = (item_nxt.year[1:0] == 2'd0) && (!div25 || (item_nxt.year[3:0] == 4'd0));
  end

  assign in_tready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      s1_item_r <= item_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

  a_leap_div4: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_item_r.leap |-> s1_item_r.year[1:0] == 2'd0)
    else $error("leap flag on a year not divisible by four");

  a_leap_div16: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (s1_item_r.year[3:0] == 4'd0) |-> s1_item_r.leap)
    else $error("year divisible by sixteen not flagged leap");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_ready |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled input word lost or changed");

endmodule

// ===== rtl/core/tes_calc.sv =====
// Elapsed-seconds datapath: previous timestamp state and the result register.
// Depends on tes_pkg; fed by tes_in_stage.
module tes_calc (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s1_valid,
  output logic                            s1_ready,
  input  tes_pkg::tes_item_t              s1_item,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tes_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import tes_pkg::*;

  logic                     out_valid_r;
  logic [ELAPSED_W-1:0]     out_data_r;
  logic [ELAPSED_W-1:0]     out_data_nxt;
  logic                     have_last_r;
  logic [YEAR_W-1:0]        last_year_r;
  logic                     last_leap_r;
  logic signed [HRS_W-1:0]  last_hrs_r;
  logic [SOH_W-1:0]         last_soh_r;
  logic signed [HRS_W-1:0]  new_hrs;
  logic [SOH_W-1:0]         new_soh;
  logic signed [15:0]       new_h;
  logic signed [15:0]       diff_h;
  logic signed [12:0]       diff_s;
  logic signed [27:0]       prod;
  logic signed [27:0]       total;
  logic                     xfer;

  assign s1_ready = !out_valid_r || out_tready;
  assign xfer     = s1_valid && s1_ready;

  always_comb begin
    new_hrs = hours_into_year(s1_item.leap, s1_item.month, s1_item.day, s1_item.hour);
    new_soh = 12'(s1_item.minute) * 12'd60 + 12'(s1_item.second);
    new_h   = 16'(new_hrs);
    if (s1_item.year > last_year_r) begin
      new_h = new_h + $signed({2'b00, (last_leap_r ? HOURS_LEAP_YEAR : HOURS_YEAR)});
    end
    diff_h = new_h - 16'(last_hrs_r);
    diff_s = $signed({1'b0, new_soh}) - $signed({1'b0, last_soh_r});
    prod   = 28'(diff_h) * 28'sd3600;
    total  = prod + 28'(diff_s);
    if (!have_last_r || (total <= 28'sd1)) begin
      out_data_nxt = '0;
    end else begin
      out_data_nxt = total[ELAPSED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      have_last_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        out_valid_r <= s1_valid;
      end
      if (xfer) begin
        have_last_r <= (s1_item.month != MONTH_UNSET);
      end
    end
    if (xfer) begin
      out_data_r  <= out_data_nxt;
      last_year_r <= s1_item.year;
      last_leap_r <= s1_item.leap;
      last_hrs_r  <= new_hrs;
      last_soh_r  <= new_soh;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-ELAPSED_W){1'b0}}, out_data_r};

  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && !have_last_r |=> out_data_r == '0)
    else $error("nonzero result without a stored timestamp");

  a_never_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r != 26'd1)
    else $error("result of one second not cleared");

  a_have_last: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |=> have_last_r == ($past(s1_item.month) != MONTH_UNSET))
    else $error("stored-timestamp flag does not follow the month");

endmodule

// ===== rtl/core/timestamp_elapsed_seconds.sv =====
// Top level of the timestamp elapsed-seconds block.
// Depends on tes_pkg, tes_in_stage and tes_calc.
//
//  channel | dir | word
//  in_     | in  | one calendar timestamp (40 bits)
//  out_    | out | seconds since the previous timestamp (26 bits in 32)
//
// One word per cycle while the result is not stalled. Each result passes
// through the input register and then the result register, with the
// month table, the year-hour add and the x3600 multiply between them.
// Reset clears the stored timestamp; the first result after reset is 0.
// A stalled result holds the pipeline; in_tready drops once both stages fill.
module timestamp_elapsed_seconds (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28], second[39:34]
  input  logic [tes_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // elapsed_seconds[25:0], zero fill [31:26]
  output logic [tes_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import tes_pkg::*;

  logic      s1_valid;
  logic      s1_ready;
  tes_item_t s1_item;

  tes_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_item   (s1_item)
  );

  tes_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_item    (s1_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
